// File: hdl/itpd_pkg.sv
// ----------------------------------------------------------------------------
// Indexed texture pixel decoder package
// Shared widths, format codes, the pixel record and the 5-bit channel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package itpd_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	localparam int unsigned IDX_W       = 8;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned S_TDATA_W   = 72;
	localparam int unsigned M_TDATA_W   = 32;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 3;
	localparam int unsigned IMG_FMT_W   = 3;
	localparam int unsigned PAL_FMT_W   = 2;

	// Command carried in the input tuser.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_FORMAT   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_FORMAT = 1'b1;

	// Source texel formats.
	localparam logic [IMG_FMT_W-1:0] IMG_A1BGR5 = 3'd0;
	localparam logic [IMG_FMT_W-1:0] IMG_XBGR8  = 3'd1;
	localparam logic [IMG_FMT_W-1:0] IMG_RGBA8  = 3'd2;
	localparam logic [IMG_FMT_W-1:0] IMG_CLUT4  = 3'd3;
	localparam logic [IMG_FMT_W-1:0] IMG_CLUT8  = 3'd4;

	// Palette entry formats.
	localparam logic [PAL_FMT_W-1:0] PAL_NONE   = 2'd0;
	localparam logic [PAL_FMT_W-1:0] PAL_A1BGR5 = 2'd1;
	localparam logic [PAL_FMT_W-1:0] PAL_XBGR8  = 2'd2;
	localparam logic [PAL_FMT_W-1:0] PAL_ABGR8  = 2'd3;

	// floor(v * 255 / 31) as v * 255 * ceil(2^20 / 31) >> 20; exact for 5-bit v.
	localparam logic [28:0] EXPAND5_MUL = 29'd8625630;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
		logic       bad;
	} pixel_t;

	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [28:0] prod;
		prod = 29'(v) * EXPAND5_MUL;
		return prod[27:20];
	endfunction

endpackage

`default_nettype wire

// File: hdl/itpd_palette_ram.sv
// ----------------------------------------------------------------------------
// Palette memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itpd_palette_ram #(
	parameter int unsigned DEPTH = itpd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DEPTH)-1:0]      waddr,
	input  wire logic [itpd_pkg::WORD_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr0,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr1,
	output logic      [itpd_pkg::WORD_W-1:0]   rdata0_q,
	output logic      [itpd_pkg::WORD_W-1:0]   rdata1_q
);

	logic [itpd_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0_q <= mem[raddr0];
			rdata1_q <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

// File: hdl/itpd_pixel_format.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Turns a direct texel or up to two palette entries into RGBA8 pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module itpd_pixel_format (
	input  wire logic [itpd_pkg::IMG_FMT_W-1:0] image_format,
	input  wire logic [itpd_pkg::PAL_FMT_W-1:0] palette_format,
	input  wire logic [itpd_pkg::WORD_W-1:0]    texel,
	input  wire logic [itpd_pkg::WORD_W-1:0]    entry0,
	input  wire logic [itpd_pkg::WORD_W-1:0]    entry1,
	output itpd_pkg::pixel_t                    pix0,
	output itpd_pkg::pixel_t                    pix1,
	output logic                                two
);

	function automatic itpd_pkg::pixel_t from_a1bgr5(input logic [15:0] p, input logic last);
		itpd_pkg::pixel_t px;
		px.red   = itpd_pkg::expand5(p[4:0]);
		px.green = itpd_pkg::expand5(p[9:5]);
		px.blue  = itpd_pkg::expand5(p[14:10]);
		px.alpha = p[15] ? 8'hFF : 8'h00;
		px.last  = last;
		px.bad   = 1'b0;
		return px;
	endfunction

	function automatic itpd_pkg::pixel_t from_bgr8(input logic [31:0] w, input logic own_alpha,
		input logic last);
		itpd_pkg::pixel_t px;
		px.red   = w[7:0];
		px.green = w[15:8];
		px.blue  = w[23:16];
		px.alpha = own_alpha ? w[31:24] : 8'hFF;
		px.last  = last;
		px.bad   = 1'b0;
		return px;
	endfunction

	function automatic itpd_pkg::pixel_t bad_pixel(input logic last);
		itpd_pkg::pixel_t px;
		px       = '0;
		px.last  = last;
		px.bad   = 1'b1;
		return px;
	endfunction

	function automatic itpd_pkg::pixel_t from_entry(input logic [itpd_pkg::PAL_FMT_W-1:0] pf,
		input logic [31:0] e, input logic last);
		itpd_pkg::pixel_t px;
		unique case (pf)
			itpd_pkg::PAL_A1BGR5: px = from_a1bgr5(e[15:0], last);
			itpd_pkg::PAL_XBGR8:  px = from_bgr8(e, 1'b0, last);
			itpd_pkg::PAL_ABGR8:  px = from_bgr8(e, 1'b1, last);
			default:              px = bad_pixel(last);
		endcase
		return px;
	endfunction

	always_comb begin
		pix1 = from_entry(palette_format, entry1, 1'b1);
		two  = 1'b0;
		unique case (image_format)
			itpd_pkg::IMG_A1BGR5: pix0 = from_a1bgr5(texel[15:0], 1'b1);
			itpd_pkg::IMG_XBGR8:  pix0 = from_bgr8(texel, 1'b0, 1'b1);
			itpd_pkg::IMG_RGBA8:  pix0 = from_bgr8(texel, 1'b1, 1'b1);
			itpd_pkg::IMG_CLUT4: begin
				pix0 = from_entry(palette_format, entry0, 1'b0);
				two  = 1'b1;
			end
			itpd_pkg::IMG_CLUT8:  pix0 = from_entry(palette_format, entry0, 1'b1);
			default:              pix0 = bad_pixel(1'b1);
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/itpd_out_serializer.sv
// ----------------------------------------------------------------------------
// Output serializer
// Output register with a second slot that sends a pixel pair as two transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module itpd_out_serializer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire itpd_pkg::pixel_t in_pix0,
	input  wire itpd_pkg::pixel_t in_pix1,
	input  wire logic             in_two,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output itpd_pkg::pixel_t      out_pix
);

	logic             out_valid_q;
	logic             pend_valid_q;
	itpd_pkg::pixel_t out_pix_q;
	itpd_pkg::pixel_t pend_pix_q;
	logic             shift;

	// The pending second pixel moves up when the current one is taken.
	assign shift    = out_valid_q && out_ready && pend_valid_q;
	assign in_ready = !out_valid_q || (out_ready && !pend_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (shift) begin
			pend_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q  <= in_valid;
			pend_valid_q <= in_valid && in_two;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			out_pix_q <= pend_pix_q;
		end else if (in_ready && in_valid) begin
			out_pix_q  <= in_pix0;
			pend_pix_q <= in_pix1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;

endmodule

`default_nettype wire

// File: hdl/indexed_texture_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// Indexed texture pixel decoder
// Decodes A1BGR5, XBGR8, RGBA8, CLUT4 and CLUT8 texels into RGBA8 pixels.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel. tuser selects the command: a load
// transfer writes one palette entry and produces no pixel, a decode transfer
// turns one texel into one pixel, or two pixels for CLUT4 (low nibble first).
// Pixels leave on the m_axis channel; tlast marks the final pixel of a texel
// and tuser flags a texel that cannot be decoded (color bytes then zero).
// The format registers are written through cfg_we/cfg_index/cfg_data while
// no item is in flight.
// The first pixel passes the input stage, the palette read and the format
// conversion on its way into the output register. One item is taken every
// cycle while the receiver does not stall; a CLUT4 texel holds the output
// register until both its pixels are sent, which slows a run of CLUT4
// texels. A load is visible to every decode that follows it on the stream.
// Reset clears all stage valid bits and sets image_format to RGBA8 and
// palette_format to none; the palette itself is not cleared and must be
// loaded before use. When the receiver stalls, the stages fill up behind
// the output register and s_axis_tready drops once all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_texture_pixel_decoder_unit #(
	parameter int unsigned PALETTE_ENTRIES = itpd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// Fields from bit 0: entry_index[7:0], entry_value[31:0], texel_word[31:0].
	input  wire logic [itpd_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// Fields from bit 0: command.
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// Fields from bit 0: red[7:0], green[7:0], blue[7:0], alpha[7:0].
	output logic      [itpd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	output logic                                      m_axis_tlast,
	// Fields from bit 0: bad_format.
	output logic                                      m_axis_tuser,
	input  wire logic                                 cfg_we,
	input  wire logic [itpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [itpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
	localparam logic [itpd_pkg::IDX_W:0] ENTRY_LIMIT = (itpd_pkg::IDX_W + 1)'(PALETTE_ENTRIES);

	// Configuration registers.
	logic [itpd_pkg::IMG_FMT_W-1:0] image_format_q;
	logic [itpd_pkg::PAL_FMT_W-1:0] palette_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_format_q   <= itpd_pkg::IMG_RGBA8;
			palette_format_q <= itpd_pkg::PAL_NONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				itpd_pkg::REG_IMAGE_FORMAT:   image_format_q   <= cfg_data;
				itpd_pkg::REG_PALETTE_FORMAT: palette_format_q <= cfg_data[itpd_pkg::PAL_FMT_W-1:0];
			endcase
		end
	end

	// Stage valid bits and the backward stall chain. A stage may load when it
	// is empty or when its content moves on in the same cycle.
	logic valid_s1, valid_s2, valid_s3;
	logic free_s1, free_s2, free_s3;
	logic ser_ready;

	assign free_s3       = !valid_s3 || ser_ready;
	assign free_s2       = !valid_s2 || free_s3;
	assign free_s1       = !valid_s1 || free_s2;
	assign s_axis_tready = free_s1;

	// Stage 1: the captured input transfer.
	logic                           cmd_s1;
	logic [itpd_pkg::IDX_W-1:0]     eidx_s1;
	logic [itpd_pkg::WORD_W-1:0]    eval_s1;
	logic [itpd_pkg::WORD_W-1:0]    texel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && s_axis_tvalid) begin
			cmd_s1   <= s_axis_tuser;
			eidx_s1  <= s_axis_tdata[7:0];
			eval_s1  <= s_axis_tdata[39:8];
			texel_s1 <= s_axis_tdata[71:40];
		end
	end

	// Palette indexes. CLUT4 takes both nibbles; CLUT8 exchanges index bits
	// three and four, which swaps the second and third eight-entry block of
	// every 32-entry group.
	logic [itpd_pkg::IDX_W-1:0] idx0, idx1;
	logic                       hit0, hit1, load_hit;
	logic                       is_decode_s1;

	always_comb begin
		if (image_format_q == itpd_pkg::IMG_CLUT4) begin
			idx0 = {4'b0000, texel_s1[3:0]};
			idx1 = {4'b0000, texel_s1[7:4]};
		end else begin
			idx0 = {texel_s1[7:5], texel_s1[3], texel_s1[4], texel_s1[2:0]};
			idx1 = idx0;
		end
	end

	assign hit0         = {1'b0, idx0} < ENTRY_LIMIT;
	assign hit1         = {1'b0, idx1} < ENTRY_LIMIT;
	assign load_hit     = {1'b0, eidx_s1} < ENTRY_LIMIT;
	assign is_decode_s1 = cmd_s1 == itpd_pkg::CMD_DECODE;

	// Stage 2: palette read data, the texel and the range flags.
	logic                        ram_we, ram_re;
	logic [itpd_pkg::WORD_W-1:0] rdata0, rdata1;
	logic [itpd_pkg::WORD_W-1:0] texel_s2;
	logic                        hit0_s2, hit1_s2;

	// A load writes as it leaves stage 1; a later decode reads only after it.
	assign ram_we = free_s2 && valid_s1 && !is_decode_s1 && load_hit;
	assign ram_re = free_s2 && valid_s1 && is_decode_s1;

	itpd_palette_ram #(
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (eidx_s1[AW-1:0]),
		.wdata   (eval_s1),
		.re      (ram_re),
		.raddr0  (idx0[AW-1:0]),
		.raddr1  (idx1[AW-1:0]),
		.rdata0_q(rdata0),
		.rdata1_q(rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1 && is_decode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			texel_s2 <= texel_s1;
			hit0_s2  <= hit0;
			hit1_s2  <= hit1;
		end
	end

	// Stage 3: converted pixel pair. An index beyond the palette reads as zero.
	itpd_pkg::pixel_t            pix0, pix1;
	logic                        two;
	itpd_pkg::pixel_t            pix0_s3, pix1_s3;
	logic                        two_s3;
	logic [itpd_pkg::WORD_W-1:0] entry0, entry1;

	assign entry0 = hit0_s2 ? rdata0 : '0;
	assign entry1 = hit1_s2 ? rdata1 : '0;

	itpd_pixel_format u_format (
		.image_format  (image_format_q),
		.palette_format(palette_format_q),
		.texel         (texel_s2),
		.entry0        (entry0),
		.entry1        (entry1),
		.pix0          (pix0),
		.pix1          (pix1),
		.two           (two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			pix0_s3 <= pix0;
			pix1_s3 <= pix1;
			two_s3  <= two;
		end
	end

	// Output register; splits a CLUT4 pair into two transfers.
	itpd_pkg::pixel_t out_pix;

	itpd_out_serializer u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_ready (ser_ready),
		.in_pix0  (pix0_s3),
		.in_pix1  (pix1_s3),
		.in_two   (two_s3),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_pix  (out_pix)
	);

	assign m_axis_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};
	assign m_axis_tlast = out_pix.last;
	assign m_axis_tuser = out_pix.bad;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed texture pixel decoder testbench
// Streams palette loads and texels through the decoder under changing image
// and palette formats, with bursty input and a stalling receiver, and checks
// every output pixel against a cycle-free model of the conversion.
// ----------------------------------------------------------------------------

module tb;

	import itpd_pkg::*;

	// Reserved image format codes; the decoder flags these as undecodable.
	localparam logic [IMG_FMT_W-1:0] IMG_RESERVED_LO = 3'd5;
	localparam logic [IMG_FMT_W-1:0] IMG_RESERVED_HI = 3'd7;

	localparam int SETTLE_CYCLES   = 8;    // Covers the four-stage pipeline after loads.
	localparam int DRAIN_CYCLES    = 12;
	localparam int LONG_HOLD       = 400;  // Receiver hold-off that fills the pipeline.
	localparam int WATCHDOG_LIMIT  = 3000; // Cycles without any transfer or register write before giving up.
	localparam int RANDOM_PHASES   = 14;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int SWEEP_LEN       = 8;

	// One stimulus item. When typed is set, the expected color and flag are
	// taken from rgba0/rgba1/bad instead of the predictor ({alpha,blue,green,red}).
	typedef struct packed {
		bit                   reconfig;
		logic [IMG_FMT_W-1:0] img;
		logic [PAL_FMT_W-1:0] pal;
		logic                 cmd;
		logic [7:0]           slot;
		logic [31:0]          entry;
		logic [31:0]          texel;
		bit                   typed;
		logic [31:0]          rgba0;
		logic [31:0]          rgba1;
		logic                 bad;
	} stim_row_t;

	// Directed rows: reset format first, then palette loads used by the CLUT
	// rows, then every image format, every palette format, ignored upper bits,
	// the CLUT8 index swap in both directions and the undecodable cases.
	localparam stim_row_t DIRECTED_ROWS [24] = '{
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h00,
		  32'h00000000, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h0F,
		  32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h05,
		  32'h80FF7C1F, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h0A,
		  32'h12345678, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h10,
		  32'h11223344, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'h08,
		  32'h9ABCDEF0, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_RGBA8, PAL_NONE, CMD_LOAD, 8'hFF,
		  32'h7F00FF01, 32'h00000000, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b1, IMG_A1BGR5, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h0000FFFF, 1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b0},
		'{1'b0, IMG_A1BGR5, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hFFFF7FFF, 1'b1, 32'h00FFFFFF, 32'h00000000, 1'b0},
		'{1'b0, IMG_A1BGR5, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00008000, 1'b1, 32'hFF000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_A1BGR5, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hABCD5A3C, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b1, IMG_XBGR8, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hAA563412, 1'b1, 32'hFF563412, 32'h00000000, 1'b0},
		'{1'b1, IMG_CLUT4, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h000000A5, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
		'{1'b1, IMG_RESERVED_HI, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
		'{1'b1, IMG_CLUT4, PAL_A1BGR5, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h000000F0, 1'b1, 32'h00000000, 32'hFFFFFFFF, 1'b0},
		'{1'b1, IMG_CLUT4, PAL_XBGR8, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h0000005A, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b1, IMG_CLUT4, PAL_ABGR8, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hFFFFFF0F, 1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b0},
		'{1'b1, IMG_CLUT8, PAL_ABGR8, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00000008, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_CLUT8, PAL_ABGR8, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00000010, 1'b0, 32'h00000000, 32'h00000000, 1'b0},
		'{1'b0, IMG_CLUT8, PAL_ABGR8, CMD_DECODE, 8'h00,
		  32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h7F00FF01, 32'h00000000, 1'b0},
		'{1'b1, IMG_CLUT8, PAL_NONE, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
		'{1'b1, IMG_CLUT8, PAL_A1BGR5, CMD_DECODE, 8'h00,
		  32'h00000000, 32'h00000005, 1'b1, 32'h00FF00FF, 32'h00000000, 1'b0}
	};

	// Format pairs visited by the first random phases; later phases pick at random,
	// leaning toward the palette formats.
	localparam logic [IMG_FMT_W-1:0] IMAGE_SWEEP [SWEEP_LEN] = '{
		IMG_A1BGR5, IMG_XBGR8, IMG_RGBA8, IMG_CLUT4,
		IMG_CLUT8, IMG_RESERVED_LO, IMG_RESERVED_HI, IMG_CLUT4
	};
	localparam logic [PAL_FMT_W-1:0] PALETTE_SWEEP [SWEEP_LEN] = '{
		PAL_NONE, PAL_NONE, PAL_NONE, PAL_ABGR8,
		PAL_A1BGR5, PAL_NONE, PAL_NONE, PAL_XBGR8
	};

	// Clock, reset and the signals that drive the decoder. Every input has a
	// known value from time zero.
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   s_tuser   = CMD_LOAD;
	logic                   m_tready  = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_FORMAT;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tuser;

	// Shadow state of the decoder: its two format registers and the palette.
	logic [IMG_FMT_W-1:0]   image_fmt   = IMG_RGBA8;
	logic [PAL_FMT_W-1:0]   palette_fmt = PAL_NONE;
	logic [31:0]            palette_words [PALETTE_ENTRIES_DEF];

	// Pixels that have been predicted but not yet seen on the output.
	pixel_t                 expected_pixels [$];

	int  failures       = 0;
	int  items_sent     = 0;
	int  loads_sent     = 0;
	int  pixels_checked = 0;
	int  settings_used  = 0;
	int  long_holds     = 0;
	int  burst_left     = 0;
	int  stalled_cycles = 0;
	bit  long_hold_req  = 1'b0;

	always #5 clk = ~clk;

	indexed_texture_pixel_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Conversion model.
	// ------------------------------------------------------------------------

	// A 5-bit channel widens to floor(v * 255 / 31).
	function automatic logic [7:0] widen5(input logic [4:0] v);
		int unsigned w;
		w = (32'(v) * 255) / 31;
		return w[7:0];
	endfunction

	function automatic pixel_t a1bgr5_pixel(input logic [15:0] p, input logic last);
		return {widen5(p[4:0]), widen5(p[9:5]), widen5(p[14:10]),
			p[15] ? 8'hFF : 8'h00, last, 1'b0};
	endfunction

	// Palette entries are interpreted in the palette format in force at the read.
	function automatic pixel_t palette_pixel(input logic [7:0] slot, input logic last);
		logic [31:0] e;
		e = palette_words[slot];
		case (palette_fmt)
			PAL_A1BGR5: return a1bgr5_pixel(e[15:0], last);
			PAL_XBGR8:  return {e[7:0], e[15:8], e[23:16], 8'hFF, last, 1'b0};
			PAL_ABGR8:  return {e[7:0], e[15:8], e[23:16], e[31:24], last, 1'b0};
			default:    return {32'h0, last, 1'b1};
		endcase
	endfunction

	// Returns the number of pixels that one texel produces (one or two).
	function automatic int decode_texel(input logic [31:0] texel,
		output pixel_t lo_px, output pixel_t hi_px);
		logic [7:0] slot;
		hi_px = '0;
		case (image_fmt)
			IMG_A1BGR5: lo_px = a1bgr5_pixel(texel[15:0], 1'b1);
			IMG_XBGR8:  lo_px = {texel[7:0], texel[15:8], texel[23:16], 8'hFF, 1'b1, 1'b0};
			IMG_RGBA8:  lo_px = {texel[7:0], texel[15:8], texel[23:16], texel[31:24],
				1'b1, 1'b0};
			IMG_CLUT4: begin
				// Low nibble is the first pixel; only the second carries last.
				lo_px = palette_pixel({4'h0, texel[3:0]}, 1'b0);
				hi_px = palette_pixel({4'h0, texel[7:4]}, 1'b1);
				return 2;
			end
			IMG_CLUT8: begin
				// Swapping index bits 3 and 4 unconditionally is the same as
				// swapping them only when they differ.
				slot  = {texel[7:5], texel[3], texel[4], texel[2:0]};
				lo_px = palette_pixel(slot, 1'b1);
			end
			default:    lo_px = {32'h0, 1'b1, 1'b1};
		endcase
		return 1;
	endfunction

	// ------------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------------

	// Offers one item and waits for its transfer. The sender works in bursts;
	// a gap with tvalid low precedes every new burst, and some bursts run to
	// hundreds of items.
	task automatic send_item(input stim_row_t item);
		pixel_t lo_px;
		pixel_t hi_px;
		int     count;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= item.cmd;
		s_tdata  <= {item.texel, item.entry, item.slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		items_sent++;
		// The item has transferred: update the palette shadow or predict pixels.
		if (item.cmd == CMD_LOAD) begin
			palette_words[item.slot] = item.entry;
			loads_sent++;
		end else begin
			count = decode_texel(item.texel, lo_px, hi_px);
			if (item.typed) begin
				{lo_px.alpha, lo_px.blue, lo_px.green, lo_px.red} = item.rgba0;
				{hi_px.alpha, hi_px.blue, hi_px.green, hi_px.red} = item.rgba1;
				lo_px.bad = item.bad;
				hi_px.bad = item.bad;
			end
			expected_pixels = {expected_pixels, lo_px};
			if (count == 2) expected_pixels = {expected_pixels, hi_px};
		end
	endtask

	// Format registers change only with the decoder idle: all pixels out, and
	// time for a trailing load to leave the pipeline, since loads give no pixel.
	task automatic write_formats(input logic [IMG_FMT_W-1:0] img,
		input logic [PAL_FMT_W-1:0] pal);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_FORMAT;
		cfg_data  <= img;
		@(posedge clk);
		cfg_index <= REG_PALETTE_FORMAT;
		cfg_data  <= CFG_DATA_W'(pal);
		@(posedge clk);
		cfg_we      <= 1'b0;
		image_fmt   = img;
		palette_fmt = pal;
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus: reset, directed rows, a full palette upload, then random phases.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stim_row_t            row;
		logic [IMG_FMT_W-1:0] img;
		logic [PAL_FMT_W-1:0] pal;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].reconfig)
				write_formats(DIRECTED_ROWS[i].img, DIRECTED_ROWS[i].pal);
			send_item(DIRECTED_ROWS[i]);
		end

		// Fill every palette slot so that random CLUT texels never read an
		// entry that has not been written.
		for (int s = 0; s < PALETTE_ENTRIES_DEF; s++) begin
			row       = '0;
			row.cmd   = CMD_LOAD;
			row.slot  = 8'(s);
			row.entry = $urandom();
			send_item(row);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < SWEEP_LEN) begin
				img = IMAGE_SWEEP[p];
				pal = PALETTE_SWEEP[p];
			end else begin
				if ($urandom_range(0, 2) == 0) img = IMG_FMT_W'($urandom_range(0, 7));
				else img = $urandom_range(0, 1) ? IMG_CLUT4 : IMG_CLUT8;
				pal = PAL_FMT_W'($urandom_range(0, 3));
			end
			write_formats(img, pal);
			// Twice in the run the receiver backs off long enough to fill the
			// pipeline while the sender keeps offering texels.
			if (p == 1 || p == 10) long_hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				row       = '0;
				row.cmd   = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_DECODE;
				row.slot  = 8'($urandom());
				row.entry = $urandom();
				case ($urandom_range(0, 7))
					0:       row.texel = '0;
					1:       row.texel = '1;
					default: row.texel = $urandom();
				endcase
				send_item(row);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d palette loads) under %0d format settings;",
			items_sent, loads_sent, settings_used);
		$display("%0d pixels checked over all formats and %0d long receiver stalls.",
			pixels_checked, long_holds);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Output side.
	// ------------------------------------------------------------------------

	// The receiver alternates between ready stretches, random stalls and full
	// stops, and takes a long hold-off whenever the stimulus asks for one.
	initial begin : receiver
		int mode;
		int run;
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_holds++;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 3);
				run  = $urandom_range(1, 40);
				repeat (run) begin
					@(posedge clk);
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= 1'b0;
						default: m_tready <= ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endfunction

	// Every pixel transfer is matched against the oldest prediction.
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (m_axis_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel %h arrived with no texel pending", m_axis_tdata);
				failures++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("red", want.red, m_axis_tdata[7:0]);
				check_field("green", want.green, m_axis_tdata[15:8]);
				check_field("blue", want.blue, m_axis_tdata[23:16]);
				check_field("alpha", want.alpha, m_axis_tdata[31:24]);
				check_field("last", 8'(want.last), 8'(m_axis_tlast));
				check_field("bad_format", 8'(want.bad), 8'(m_axis_tuser));
				pixels_checked++;
			end
		end
	end

	// A run that stops moving is a hang: no transfer on either side and no
	// register write for the whole limit.
	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) || cfg_we) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles == WATCHDOG_LIMIT) begin
			$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

endmodule
